// ===== rtl/cfd_pkg.sv =====
// Shared types and constants for the clipped framebuffer draw engine.
package cfd_pkg;

    localparam int POS_W       = 16;
    localparam int COORD_W     = 10;   // holds any on-screen column/row up to 1023
    localparam int SIZE_W      = 11;   // holds a clipped size up to 1024
    localparam int COLOR_W     = 8;
    localparam int COUNT_W     = 17;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W       = 32;

    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FILL  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // clipped command handed from front to back
    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic [COLOR_W-1:0] color;
        logic               empty;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SETUP,
        B_RUN,
        B_DONE
    } t_bstate;

endpackage

// ===== rtl/clipped_framebuffer_draw_top.sv =====
// Clipped framebuffer draw engine: top level with front end, queue and back end.
// A pixel write or read accepted with an idle back end passes the front-end registers, the queue
// and the back-end states B_IDLE, B_SETUP, B_RUN, B_DONE before o_m_axis_tvalid rises.
// The back end works on one command at a time; B_RUN visits each pixel touched (w*h for a fill,
// SCREEN_WIDTH*SCREEN_HEIGHT for a clear) in turn through the single memory port. Front end
// takes one word per cycle while the 2-entry queue has room and no reset clear runs.
// Reset: a clearing pass writes color 3 to every pixel, with tready low until it ends.
module clipped_framebuffer_draw_top #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // pos_x, pos_y, rect_width, rect_height, pixel_color
    input  logic [1:0]  i_s_axis_tuser,  // op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // written_count, read_color, in_bounds, zero pad
);

    cfd_pkg::t_cmd  front_cmd, queue_cmd;
    logic           push, q_full, q_empty, pop, init_busy;

    cfd_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_op          (i_s_axis_tuser),
        .i_pos_x       (i_s_axis_tdata[15:0]),
        .i_pos_y       (i_s_axis_tdata[31:16]),
        .i_rect_width  (i_s_axis_tdata[47:32]),
        .i_rect_height (i_s_axis_tdata[63:48]),
        .i_pixel_color (i_s_axis_tdata[71:64]),
        .i_hold        (init_busy),
        .i_full        (q_full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    cfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_cmd   (queue_cmd)
    );

    cfd_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty)
        else $error("queue popped while empty");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("queue pushed while full");

    a_bounds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[25]) |-> (o_m_axis_tdata[16:0] <= 17'd1))
        else $error("on-screen pixel op reports more than one pixel written");

    a_read_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[24:17] != 8'd0) |-> o_m_axis_tdata[25])
        else $error("read color reported for an off-screen or non-read command");

endmodule

// ===== rtl/cfd_front.sv =====
// Front end: accepts commands, maps every op to a rectangle and clips it to the screen.
module cfd_front #(
    parameter int SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_op,
    input  logic signed [cfd_pkg::POS_W-1:0]    i_pos_x,
    input  logic signed [cfd_pkg::POS_W-1:0]    i_pos_y,
    input  logic signed [cfd_pkg::POS_W-1:0]    i_rect_width,
    input  logic signed [cfd_pkg::POS_W-1:0]    i_rect_height,
    input  logic [cfd_pkg::COLOR_W-1:0]         i_pixel_color,
    input  logic                                i_hold,
    input  logic                                i_full,
    output logic                                o_push,
    output cfd_pkg::t_cmd                       o_cmd
);

    localparam int PW = cfd_pkg::POS_W;
    localparam logic signed [PW:0] SW_S = (PW+1)'(SCREEN_WIDTH);
    localparam logic signed [PW:0] SH_S = (PW+1)'(SCREEN_HEIGHT);

    // stage 1: raw rectangle
    logic                               r_v1;
    cfd_pkg::t_op                       r_op1;
    logic signed [PW-1:0]               r_x1, r_y1, r_w1, r_h1;
    logic [cfd_pkg::COLOR_W-1:0]        r_c1;
    logic signed [PW-1:0]               n_x1, n_y1, n_w1, n_h1;

    // stage 2: origin clamped to zero, size shrunk
    logic                               r_v2;
    cfd_pkg::t_op                       r_op2;
    logic signed [PW:0]                 r_x2, r_y2, r_w2, r_h2;
    logic [cfd_pkg::COLOR_W-1:0]        r_c2;
    logic signed [PW:0]                 n_x2, n_y2, n_w2, n_h2;

    logic signed [PW:0]                 rem_x, rem_y, w_clip, h_clip;
    logic                               adv2, take1, empty;

    assign o_push = r_v2 && !i_full;
    assign adv2   = !r_v2 || o_push;
    assign take1  = !r_v1 || adv2;
    assign o_ready = take1 && !i_hold;

    // single pixels are 1x1 rectangles, clear is the full screen
    always_comb begin
        n_x1 = i_pos_x;
        n_y1 = i_pos_y;
        n_w1 = i_rect_width;
        n_h1 = i_rect_height;
        unique case (cfd_pkg::t_op'(i_op))
            cfd_pkg::OP_WRITE, cfd_pkg::OP_READ: begin
                n_w1 = PW'(1);
                n_h1 = PW'(1);
            end
            cfd_pkg::OP_CLEAR: begin
                n_x1 = '0;
                n_y1 = '0;
                n_w1 = PW'(SCREEN_WIDTH);
                n_h1 = PW'(SCREEN_HEIGHT);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_x2 = r_x1[PW-1] ? '0 : {r_x1[PW-1], r_x1};
        n_y2 = r_y1[PW-1] ? '0 : {r_y1[PW-1], r_y1};
        n_w2 = r_x1[PW-1] ? ({r_w1[PW-1], r_w1} + {r_x1[PW-1], r_x1}) : {r_w1[PW-1], r_w1};
        n_h2 = r_y1[PW-1] ? ({r_h1[PW-1], r_h1} + {r_y1[PW-1], r_y1}) : {r_h1[PW-1], r_h1};
    end

    always_comb begin
        rem_x  = SW_S - r_x2;
        rem_y  = SH_S - r_y2;
        w_clip = (r_w2 > rem_x) ? rem_x : r_w2;
        h_clip = (r_h2 > rem_y) ? rem_y : r_h2;
        empty  = (r_x2 >= SW_S) || (r_y2 >= SH_S) || (w_clip <= 0) || (h_clip <= 0);
        o_cmd.op    = r_op2;
        o_cmd.x     = r_x2[cfd_pkg::COORD_W-1:0];
        o_cmd.y     = r_y2[cfd_pkg::COORD_W-1:0];
        o_cmd.w     = w_clip[cfd_pkg::SIZE_W-1:0];
        o_cmd.h     = h_clip[cfd_pkg::SIZE_W-1:0];
        o_cmd.color = r_c2;
        o_cmd.empty = empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (take1) begin
                r_v1 <= i_valid && o_ready;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op1 <= cfd_pkg::t_op'(i_op);
            r_x1  <= n_x1;
            r_y1  <= n_y1;
            r_w1  <= n_w1;
            r_h1  <= n_h1;
            r_c1  <= i_pixel_color;
        end
        if (adv2 && r_v1) begin
            r_op2 <= r_op1;
            r_x2  <= n_x2;
            r_y2  <= n_y2;
            r_w2  <= n_w2;
            r_h2  <= n_h2;
            r_c2  <= r_c1;
        end
    end

endmodule

// ===== rtl/cfd_queue.sv =====
// Short command queue between front end and drawing back end.
module cfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfd_pkg::t_cmd   i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output cfd_pkg::t_cmd   o_cmd
);

    cfd_pkg::t_cmd                  r_slot [cfd_pkg::QUEUE_DEPTH];
    logic [cfd_pkg::QPTR_W-1:0]     r_wr_ptr, r_rd_ptr;
    logic [cfd_pkg::QCNT_W-1:0]     r_cnt;

    assign o_full  = r_cnt == cfd_pkg::QCNT_W'(cfd_pkg::QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + cfd_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + cfd_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + cfd_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - cfd_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/cfd_back.sv =====
// Back end: framebuffer memory and the pixel sequencer that writes and reads it.
module cfd_back #(
    parameter int SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  cfd_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    output logic                        o_init_busy,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [cfd_pkg::OUT_W-1:0]   o_data
);

    localparam int PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW     = $clog2(PIXELS);
    localparam int SZ     = cfd_pkg::SIZE_W;
    localparam int CW     = cfd_pkg::COUNT_W;

    cfd_pkg::t_bstate               r_state, n_state;
    logic                           r_init;
    cfd_pkg::t_cmd                  r_cmd;
    logic [AW-1:0]                  r_addr, r_step;
    logic [SZ-1:0]                  r_col, r_rows;
    logic [CW-1:0]                  r_count;
    logic [cfd_pkg::COLOR_W-1:0]    r_rd;
    logic [cfd_pkg::COLOR_W-1:0]    r_mem [PIXELS];
    logic                           r_out_valid;
    logic [cfd_pkg::OUT_W-1:0]      r_out_data;

    logic                           we, row_end, out_load, is_pixel;
    logic [cfd_pkg::COLOR_W-1:0]    rd_color;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfd_pkg::B_IDLE:  if (!i_q_empty) n_state = cfd_pkg::B_SETUP;
            cfd_pkg::B_SETUP: n_state = r_cmd.empty ? cfd_pkg::B_DONE : cfd_pkg::B_RUN;
            cfd_pkg::B_RUN: begin
                if (row_end && r_rows == SZ'(1)) n_state = cfd_pkg::B_DONE;
            end
            cfd_pkg::B_DONE: begin
                if (r_init || !r_out_valid || i_ready) n_state = cfd_pkg::B_IDLE;
            end
            default: n_state = cfd_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = (r_state == cfd_pkg::B_IDLE) && !i_q_empty;
        we       = (r_state == cfd_pkg::B_RUN) && (r_cmd.op != cfd_pkg::OP_READ);
        row_end  = r_col == (r_cmd.w - SZ'(1));
        out_load = (r_state == cfd_pkg::B_DONE) && !r_init && (!r_out_valid || i_ready);
        is_pixel = (r_cmd.op == cfd_pkg::OP_WRITE) || (r_cmd.op == cfd_pkg::OP_READ);
        rd_color = (r_cmd.op == cfd_pkg::OP_READ && !r_cmd.empty) ? r_rd : '0;
    end

    assign o_init_busy = r_init;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;

    // reset starts a full-screen clear to the reset color that reports no result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfd_pkg::B_SETUP;
            r_init      <= 1'b1;
            r_out_valid <= 1'b0;
            r_cmd.op    <= cfd_pkg::OP_CLEAR;
            r_cmd.x     <= '0;
            r_cmd.y     <= '0;
            r_cmd.w     <= SZ'(SCREEN_WIDTH);
            r_cmd.h     <= SZ'(SCREEN_HEIGHT);
            r_cmd.color <= cfd_pkg::RESET_COLOR;
            r_cmd.empty <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_cmd <= i_cmd;
            end
            if (r_state == cfd_pkg::B_DONE && r_init) begin
                r_init <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cfd_pkg::B_SETUP) begin
            r_addr  <= AW'(r_cmd.y) * AW'(SCREEN_WIDTH) + AW'(r_cmd.x);
            r_step  <= AW'(SCREEN_WIDTH) - AW'(r_cmd.w) + AW'(1);
            r_col   <= '0;
            r_rows  <= r_cmd.h;
            r_count <= '0;
        end else if (r_state == cfd_pkg::B_RUN) begin
            if (we) begin
                r_count <= r_count + CW'(1);   // wraps, i.e. masked to 17 bits
            end
            if (row_end) begin
                r_col  <= '0;
                r_rows <= r_rows - SZ'(1);
                r_addr <= r_addr + r_step;
            end else begin
                r_col  <= r_col + SZ'(1);
                r_addr <= r_addr + AW'(1);
            end
        end
        if (out_load) begin
            r_out_data <= {{(cfd_pkg::OUT_W - CW - cfd_pkg::COLOR_W - 1){1'b0}},
                           is_pixel && !r_cmd.empty, rd_color, r_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_addr] <= r_cmd.color;
        end
        if (r_state == cfd_pkg::B_RUN) begin
            r_rd <= r_mem[r_addr];
        end
    end

endmodule
